// ===== src/lsm_pkg.sv =====
// lsm_pkg: shared types and constants for the LIFO stack with multipop.
// Holds the request/response item structs, opcode/status codes and FSM states.
// No dependencies.
`default_nettype none
package lsm_pkg;

   localparam int DEPTH        = 256;
   localparam int ADDR_W       = $clog2(DEPTH);
   localparam int PTR_W        = $clog2(DEPTH + 1);
   localparam int MAX_MULTIPOP = 64;
   localparam int CNT_W        = 7;
   localparam int DATA_W       = 32;

   typedef enum logic [1:0] {
      OP_PUSH     = 2'd0,
      OP_POP      = 2'd1,
      OP_PEEK     = 2'd2,
      OP_MULTIPOP = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_POP  = 1'b1
   } state_type;

   typedef struct packed {
      opcode_type                 opcode;
      logic signed [DATA_W-1:0]   push_value;
      logic        [CNT_W-1:0]    pop_count;
   } req_item_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]   item_value;
      logic                       value_valid;
      logic        [1:0]          status;
      logic        [CNT_W-1:0]    popped_count;
      logic                       stack_empty;
      logic                       last;
   } rsp_item_type;

endpackage
`default_nettype wire

// ===== src/lifo_stack_with_multipop.sv =====
// lifo_stack_with_multipop: top level, 256 x 32-bit stack with push/pop/peek/multipop.
// Depends on lsm_pkg.
//
// Each item is one operation. Push, and any operation that finds the stack empty or
// a multipop with a zero count, is answered with busy low: the result strobes on the
// cycle after start, so such items may be issued every cycle. Pop and peek hold busy
// in the S_POP state (the registered read of the entry store), so a new item waits.
// A multipop that removes n entries (count saturated at 64 and limited to the entries
// held) first reads the top entry, then gives one result per cycle from the single
// read port, the last marked and carrying n.
// Results are held for exactly one cycle on rsp_strobe and cannot be stalled.
// The entry store needs no clearing pass after reset.
`default_nettype none
module lifo_stack_with_multipop (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   output logic                 busy,
   input  wire lsm_pkg::req_item_type req_item,
   output logic                 rsp_strobe,
   output lsm_pkg::rsp_item_type rsp_item
);
   import lsm_pkg::*;

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;

   state_type         state_ff, state_in;
   logic [PTR_W-1:0]  sp_ff, sp_in;
   logic [CNT_W-1:0]  remaining_ff, remaining_in;
   logic [CNT_W-1:0]  done_ff, done_in;
   opcode_type        op_ff, op_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_item_type      rsp_item_ff, rsp_item_in;

   logic [CNT_W-1:0]  k_sat;
   logic [CNT_W-1:0]  n_pop;
   logic              fin;

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   // top entry while idle, next entry below the top once a pop is underway
   assign rd_addr = (state_ff == S_POP) ? sp_ff[ADDR_W-1:0] - ADDR_W'(2)
                                        : sp_ff[ADDR_W-1:0] - ADDR_W'(1);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[sp_ff[ADDR_W-1:0]] <= req_item.push_value;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   always_comb begin
      k_sat = (req_item.pop_count > CNT_W'(MAX_MULTIPOP)) ? CNT_W'(MAX_MULTIPOP)
                                                          : req_item.pop_count;
      if (PTR_W'(k_sat) < sp_ff) begin
         n_pop = k_sat;
      end else begin
         n_pop = sp_ff[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         sp_ff         <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sp_ff         <= sp_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      remaining_ff <= remaining_in;
      done_ff      <= done_in;
      op_ff        <= op_in;
      rsp_item_ff  <= rsp_item_in;
   end

   always_comb begin
      state_in      = state_ff;
      sp_in         = sp_ff;
      remaining_in  = remaining_ff;
      done_in       = done_ff;
      op_in         = op_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = rsp_item_ff;
      wr_en         = 1'b0;
      fin           = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               rsp_item_in = '0;
               rsp_item_in.last = 1'b1;
               case (req_item.opcode)
                  OP_PUSH: begin
                     rsp_strobe_in = 1'b1;
                     if (sp_ff == PTR_W'(DEPTH)) begin
                        rsp_item_in.status = ST_FULL;
                     end else begin
                        wr_en = 1'b1;
                        sp_in = sp_ff + PTR_W'(1);
                        rsp_item_in.status = ST_OK;
                     end
                  end
                  OP_POP, OP_PEEK: begin
                     if (sp_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_item_in.status = ST_EMPTY;
                     end else begin
                        state_in     = S_POP;
                        remaining_in = CNT_W'(1);
                        done_in      = '0;
                        op_in        = req_item.opcode;
                     end
                  end
                  OP_MULTIPOP: begin
                     if (sp_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_item_in.status = ST_EMPTY;
                     end else if (k_sat == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_item_in.status = ST_OK;
                     end else begin
                        state_in     = S_POP;
                        remaining_in = n_pop;
                        done_in      = '0;
                        op_in        = req_item.opcode;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_item_in.stack_empty = (sp_in == '0);
            end
         end
         S_POP: begin
            fin           = (remaining_ff == CNT_W'(1));
            rsp_strobe_in = 1'b1;
            if (op_ff != OP_PEEK) begin
               sp_in = sp_ff - PTR_W'(1);
            end
            rsp_item_in.item_value   = rd_data_ff;
            rsp_item_in.value_valid  = 1'b1;
            rsp_item_in.status       = ST_OK;
            rsp_item_in.last         = fin;
            rsp_item_in.popped_count = (fin && op_ff == OP_MULTIPOP) ? done_ff + CNT_W'(1)
                                                                   : '0;
            rsp_item_in.stack_empty  = (sp_in == '0);
            remaining_in = remaining_ff - CNT_W'(1);
            done_in      = done_ff + CNT_W'(1);
            if (fin) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= PTR_W'(DEPTH))
      else $error("stack pointer beyond depth");

   a_pop_has_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP) |-> (remaining_ff != '0 && sp_ff != '0))
      else $error("pop state with nothing to remove");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP && remaining_ff == CNT_W'(1)) |=> (state_ff == S_IDLE))
      else $error("pop sequence did not end on last item");

   a_valid_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_item_ff.value_valid) |-> (rsp_item_ff.status == ST_OK))
      else $error("value with non-ok status");

   a_pop_strobes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP) |=> rsp_strobe_ff)
      else $error("pop cycle produced no item");

endmodule
`default_nettype wire

// ===== bench/tb_lifo_stack_with_multipop.sv =====
// tb_lifo_stack_with_multipop: self-checking bench for the multipop LIFO stack.
// A directed table, then random and fill/drain phases, checked against a local stack model.
// Depends on lsm_pkg and lifo_stack_with_multipop.
`timescale 1ns / 100ps
module tb_lifo_stack_with_multipop;
   import lsm_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   typedef struct {
      opcode_type               op;
      logic signed [DATA_W-1:0] value;
      logic        [CNT_W-1:0]  count;
      bit                       typed;
      logic signed [DATA_W-1:0] e_value;
      logic                     e_valid;
      status_type               e_status;
      logic        [CNT_W-1:0]  e_count;
      logic                     e_empty;
   } dir_row_type;

   localparam int N_DIR = 24;

   dir_row_type dir_table [0:N_DIR-1] = '{
      '{OP_POP,      32'h0,        7'd0,   1, 32'h0,        1'b0, ST_EMPTY, 7'd0, 1'b1},
      '{OP_PEEK,     32'h12345678, 7'd0,   1, 32'h0,        1'b0, ST_EMPTY, 7'd0, 1'b1},
      '{OP_MULTIPOP, 32'h0,        7'd5,   1, 32'h0,        1'b0, ST_EMPTY, 7'd0, 1'b1},
      '{OP_MULTIPOP, 32'h0,        7'd0,   1, 32'h0,        1'b0, ST_EMPTY, 7'd0, 1'b1},
      '{OP_PUSH,     32'h7fffffff, 7'd0,   1, 32'h0,        1'b0, ST_OK,    7'd0, 1'b0},
      '{OP_PUSH,     32'h80000000, 7'd127, 1, 32'h0,        1'b0, ST_OK,    7'd0, 1'b0},
      '{OP_PUSH,     32'h0,        7'd0,   1, 32'h0,        1'b0, ST_OK,    7'd0, 1'b0},
      '{OP_PUSH,     32'hffffffff, 7'd1,   1, 32'h0,        1'b0, ST_OK,    7'd0, 1'b0},
      '{OP_PEEK,     32'h0,        7'd3,   1, 32'hffffffff, 1'b1, ST_OK,    7'd0, 1'b0},
      '{OP_MULTIPOP, 32'h0,        7'd0,   1, 32'h0,        1'b0, ST_OK,    7'd0, 1'b0},
      '{OP_POP,      32'h0,        7'd0,   0, 32'h0,        1'b0, ST_OK,    7'd0, 1'b0},
      '{OP_MULTIPOP, 32'h0,        7'd2,   0, 32'h0,        1'b0, ST_OK,    7'd0, 1'b0},
      '{OP_PEEK,     32'h0,        7'd0,   1, 32'h7fffffff, 1'b1, ST_OK,    7'd0, 1'b0},
      '{OP_POP,      32'h0,        7'd0,   1, 32'h7fffffff, 1'b1, ST_OK,    7'd0, 1'b1},
      '{OP_PUSH,     32'h1,        7'd0,   0, 32'h0,        1'b0, ST_OK,    7'd0, 1'b0},
      '{OP_PUSH,     32'h2,        7'd0,   0, 32'h0,        1'b0, ST_OK,    7'd0, 1'b0},
      '{OP_PUSH,     32'h3,        7'd0,   0, 32'h0,        1'b0, ST_OK,    7'd0, 1'b0},
      '{OP_PUSH,     32'h4,        7'd0,   0, 32'h0,        1'b0, ST_OK,    7'd0, 1'b0},
      '{OP_PUSH,     32'h5,        7'd0,   0, 32'h0,        1'b0, ST_OK,    7'd0, 1'b0},
      '{OP_MULTIPOP, 32'h0,        7'd127, 0, 32'h0,        1'b0, ST_OK,    7'd0, 1'b0},
      '{OP_PUSH,     32'ha5a5a5a5, 7'd0,   0, 32'h0,        1'b0, ST_OK,    7'd0, 1'b0},
      '{OP_PUSH,     32'h5a5a5a5a, 7'd0,   0, 32'h0,        1'b0, ST_OK,    7'd0, 1'b0},
      '{OP_MULTIPOP, 32'h0,        7'd64,  0, 32'h0,        1'b0, ST_OK,    7'd0, 1'b0},
      '{OP_PEEK,     32'h0,        7'd0,   1, 32'h0,        1'b0, ST_EMPTY, 7'd0, 1'b1}
   };

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   req_item_type req_item = '0;
   logic         busy;
   logic         rsp_strobe;
   rsp_item_type rsp_item;

   logic signed [DATA_W-1:0] stack_words [DEPTH];
   int           words_held;
   rsp_item_type pending_rsps [$];
   int           errors;
   int           items_sent;
   int           rsps_checked;
   int           full_hits;
   int           cycles;
   bit           burst_mode;

   lifo_stack_with_multipop i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic rsp_item_type mk_rsp(input logic signed [DATA_W-1:0] v,
                                           input logic vld, input status_type st,
                                           input logic [CNT_W-1:0] cnt, input logic lst);
      rsp_item_type r;
      r.item_value   = v;
      r.value_valid  = vld;
      r.status       = st;
      r.popped_count = cnt;
      r.stack_empty  = (words_held == 0);
      r.last         = lst;
      return r;
   endfunction

   // stack model: queues every result the operation causes
   function automatic void apply_op(input req_item_type it);
      int k;
      int n;
      logic signed [DATA_W-1:0] v;
      case (it.opcode)
         OP_PUSH: begin
            if (words_held >= DEPTH) begin
               full_hits++;
               pending_rsps.push_back(mk_rsp(0, 1'b0, ST_FULL, 0, 1'b1));
            end else begin
               stack_words[words_held] = it.push_value;
               words_held++;
               pending_rsps.push_back(mk_rsp(0, 1'b0, ST_OK, 0, 1'b1));
            end
         end
         OP_POP, OP_PEEK: begin
            if (words_held == 0) begin
               pending_rsps.push_back(mk_rsp(0, 1'b0, ST_EMPTY, 0, 1'b1));
            end else begin
               v = stack_words[words_held-1];
               if (it.opcode == OP_POP) words_held--;
               pending_rsps.push_back(mk_rsp(v, 1'b1, ST_OK, 0, 1'b1));
            end
         end
         default: begin
            k = (it.pop_count > MAX_MULTIPOP) ? MAX_MULTIPOP : int'(it.pop_count);
            if (words_held == 0) begin
               pending_rsps.push_back(mk_rsp(0, 1'b0, ST_EMPTY, 0, 1'b1));
            end else if (k == 0) begin
               pending_rsps.push_back(mk_rsp(0, 1'b0, ST_OK, 0, 1'b1));
            end else begin
               n = (k < words_held) ? k : words_held;
               for (int i = 0; i < n; i++) begin
                  v = stack_words[words_held-1];
                  words_held--;
                  pending_rsps.push_back(mk_rsp(v, 1'b1, ST_OK,
                                                (i == n-1) ? CNT_W'(n) : '0, i == n-1));
               end
            end
         end
      endcase
   endfunction

   function automatic req_item_type rand_item();
      req_item_type it;
      int r;
      r = $urandom_range(0, 99);
      if (r < 45)      it.opcode = OP_PUSH;
      else if (r < 65) it.opcode = OP_POP;
      else if (r < 80) it.opcode = OP_PEEK;
      else             it.opcode = OP_MULTIPOP;
      r = $urandom_range(0, 19);
      if (r == 0)      it.push_value = 32'sh80000000;
      else if (r == 1) it.push_value = 32'sh7fffffff;
      else             it.push_value = $urandom;
      r = $urandom_range(0, 9);
      if (r == 0)      it.pop_count = '0;
      else if (r <= 6) it.pop_count = CNT_W'($urandom_range(1, 8));
      else if (r == 7) it.pop_count = CNT_W'(MAX_MULTIPOP);
      else             it.pop_count = CNT_W'($urandom_range(0, 127));
      return it;
   endfunction

   // drive one item, wait for acceptance, then predict; a typed row overrides the prediction
   task automatic issue(input req_item_type it, input bit typed, input rsp_item_type want);
      int gap;
      if ($urandom_range(0, 15) == 0) burst_mode = !burst_mode;
      gap = burst_mode ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (busy) @(posedge clock);
      apply_op(it);
      if (typed) begin
         void'(pending_rsps.pop_back());
         pending_rsps.push_back(want);
      end
      items_sent++;
   endtask

   task automatic issue_rand(input req_item_type it);
      issue(it, 1'b0, '0);
   endtask

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results still expected", $time, pending_rsps.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_strobe) begin
         if (pending_rsps.size() == 0) begin
            $display("%0t: unexpected result, expected none, got %p", $time, rsp_item);
            errors++;
         end else begin
            want = pending_rsps.pop_front();
            rsps_checked++;
            if (rsp_item.item_value !== want.item_value) begin
               $display("%0t: item_value expected %0d got %0d",
                        $time, want.item_value, rsp_item.item_value);
               errors++;
            end
            if (rsp_item.value_valid !== want.value_valid) begin
               $display("%0t: value_valid expected %0b got %0b",
                        $time, want.value_valid, rsp_item.value_valid);
               errors++;
            end
            if (rsp_item.status !== want.status) begin
               $display("%0t: status expected %0d got %0d", $time, want.status, rsp_item.status);
               errors++;
            end
            if (rsp_item.popped_count !== want.popped_count) begin
               $display("%0t: popped_count expected %0d got %0d",
                        $time, want.popped_count, rsp_item.popped_count);
               errors++;
            end
            if (rsp_item.stack_empty !== want.stack_empty) begin
               $display("%0t: stack_empty expected %0b got %0b",
                        $time, want.stack_empty, rsp_item.stack_empty);
               errors++;
            end
            if (rsp_item.last !== want.last) begin
               $display("%0t: last expected %0b got %0b", $time, want.last, rsp_item.last);
               errors++;
            end
         end
      end
   end

   initial begin
      req_item_type it;
      rsp_item_type want;
      words_held = 0;
      errors = 0;
      items_sent = 0;
      rsps_checked = 0;
      full_hits = 0;
      cycles = 0;
      burst_mode = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIR; i++) begin
         it.opcode     = dir_table[i].op;
         it.push_value = dir_table[i].value;
         it.pop_count  = dir_table[i].count;
         want.item_value   = dir_table[i].e_value;
         want.value_valid  = dir_table[i].e_valid;
         want.status       = dir_table[i].e_status;
         want.popped_count = dir_table[i].e_count;
         want.stack_empty  = dir_table[i].e_empty;
         want.last         = 1'b1;
         issue(it, dir_table[i].typed, want);
      end

      for (int i = 0; i < 12; i++) issue_rand(rand_item());

      // fill to full, hit the full case, peek, then drain with pops and large multipops
      while (words_held < DEPTH) begin
         it = rand_item();
         it.opcode = OP_PUSH;
         issue_rand(it);
      end
      repeat (3) begin
         it = rand_item();
         it.opcode = OP_PUSH;
         issue_rand(it);
      end
      it = rand_item();
      it.opcode = OP_PEEK;
      issue_rand(it);
      while (words_held > 0) begin
         it = rand_item();
         it.opcode = ($urandom_range(0, 3) == 0) ? OP_POP : OP_MULTIPOP;
         it.pop_count = CNT_W'($urandom_range(40, 127));
         issue_rand(it);
      end
      it = rand_item();
      it.opcode = OP_MULTIPOP;
      issue_rand(it);

      for (int i = 0; i < 10; i++) issue_rand(rand_item());

      start <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Sent %0d items (%0d pushes on a full stack), checked %0d results in %0d cycles.",
               items_sent, full_hits, rsps_checked, cycles);
      $display("Covered empty, full, zero-count and saturated multipop, and random mixes.");
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/lsm_pkg.sv
src/lifo_stack_with_multipop.sv
bench/tb_lifo_stack_with_multipop.sv
